// ----- rtl/base64_stream_encoder_unit_assert.svh -----
// Assertion macros shared by the encoder's checker.
`ifndef BASE64_STREAM_ENCODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_ENCODER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define B64E_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("base64 encoder check failed");

// Check a property on every clock edge, reset included.
`define B64E_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("base64 encoder reset check failed");

`endif

// ----- rtl/b64e_pkg.sv -----
// Shared types, constants and the sextet-to-ASCII map of the base64 encoder.
package b64e_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam logic [6:0] PAD_CHAR = 7'h3D;

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    // One byte's worth of characters, waiting for the serializer.
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      last_idx;
        logic            eom;
    } t_job;

    // Queue head as the serializer sees it.
    typedef struct packed {
        t_job job;
        logic empty;
    } t_head;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] w;
        logic [6:0] c;
        begin
            w = {1'b0, v};
            if (v < 6'd26) begin
                c = w + 7'd65;
            end else if (v < 6'd52) begin
                c = w + 7'd71;
            end else if (v < 6'd62) begin
                c = w - 7'd4;
            end else if (v == 6'd62) begin
                c = 7'h2B;
            end else begin
                c = 7'h2F;
            end
            return c;
        end
    endfunction

endpackage

// ----- rtl/b64e_front.sv -----
// Front end: accept bytes, track the group phase, build character jobs.
module b64e_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_message,
    output b64e_pkg::t_job o_job
);
    import b64e_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_left, n_left;
    t_phase     mid_phase;
    logic [3:0] mid_left;
    t_job       job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_left  <= 4'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    always_comb begin
        job.chars    = {4{PAD_CHAR}};
        job.last_idx = 2'd0;
        job.eom      = i_end_of_message;
        unique case (r_phase)
            PH_1: begin
                job.chars[0] = sextet_char({r_left[1:0], i_data_byte[7:4]});
                mid_left     = i_data_byte[3:0];
                mid_phase    = PH_2;
            end
            PH_2: begin
                job.chars[0] = sextet_char({r_left, i_data_byte[7:6]});
                job.chars[1] = sextet_char(i_data_byte[5:0]);
                job.last_idx = 2'd1;
                mid_left     = 4'd0;
                mid_phase    = PH_0;
            end
            default: begin
                // the unused phase code behaves as the start of a group
                job.chars[0] = sextet_char(i_data_byte[7:2]);
                mid_left     = {2'b00, i_data_byte[1:0]};
                mid_phase    = PH_1;
            end
        endcase

        n_phase = mid_phase;
        n_left  = mid_left;
        if (i_end_of_message) begin
            // flush the leftover bits zero-padded, then fill the group with '='
            if (mid_phase == PH_1) begin
                job.chars[1] = sextet_char({mid_left[1:0], 4'b0000});
                job.last_idx = 2'd3;
            end else if (mid_phase == PH_2) begin
                job.chars[1] = sextet_char({mid_left, 2'b00});
                job.last_idx = 2'd2;
            end
            n_phase = PH_0;
            n_left  = 4'd0;
        end
        o_job = job;
    end

endmodule

// ----- rtl/b64e_queue.sv -----
// Short job queue between the front end and the serializer.
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64e_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output b64e_pkg::t_head o_head
);
    import b64e_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    assign o_full       = (r_count == FULL_CNT);
    assign o_head.empty = (r_count == '0);
    assign o_head.job   = r_mem[r_rd_ptr];

endmodule

// ----- rtl/b64e_back.sv -----
// Serializer: one head-job character per cycle into the output register unless stalled.
module b64e_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  b64e_pkg::t_head i_head,
    input  logic            i_stall,
    output logic            o_pop,
    output logic            o_valid,
    output logic [6:0]      o_out_char,
    output logic            o_last_char
);
    import b64e_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [6:0] r_char;
    logic       r_last;
    logic       load;
    logic       take;
    logic       at_end;

    assign load   = !r_valid || !i_stall;
    assign take   = load && !i_head.empty;
    assign at_end = (r_idx == i_head.job.last_idx);
    assign o_pop  = take && at_end;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (load) begin
            n_valid = !i_head.empty;
        end
        if (take) begin
            n_idx = at_end ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_char <= i_head.job.chars[r_idx];
            r_last <= i_head.job.eom && at_end;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule

// ----- rtl/base64_stream_encoder_unit.sv -----
// Output path: a byte's characters are written into the job queue, then loaded into the output register for o_out_char.
// Throughput: one character per cycle at the output while i_stall is low; a byte is taken every cycle while the
//   job queue has room, so the output port sets the pace.
// Reset: synchronous, active low; clears group phase, leftover bits, queue and output valid.
module base64_stream_encoder_unit #(
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_out_char,
    output logic       o_last_char
);
    import b64e_pkg::*;

    t_job  front_job;
    t_head head;
    logic  accept;
    logic  q_full;
    logic  pop;

    // The stall seen upstream comes only from queue occupancy, never from i_valid.
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    // Front end: classify the byte by group phase and build all its characters at once.
    b64e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_job            (front_job)
    );

    // Hold finished jobs so the front keeps taking bytes while the output is stalled.
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    // Back end: advance one character per cycle unless stalled; drop the job after its last character.
    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_stall     (i_stall),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

// ----- rtl/b64e_checker.sv -----
// Port-level checker for the base64 encoder and its bind.
`include "base64_stream_encoder_unit_assert.svh"

module b64e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_data_byte,
    input logic       i_end_of_message,
    input logic       o_valid,
    input logic       i_stall,
    input logic [6:0] o_out_char,
    input logic       o_last_char
);
    import b64e_pkg::*;

    logic legal_char;

    assign legal_char = (o_out_char >= 7'h41 && o_out_char <= 7'h5A)
                     || (o_out_char >= 7'h61 && o_out_char <= 7'h7A)
                     || (o_out_char >= 7'h30 && o_out_char <= 7'h39)
                     || o_out_char == 7'h2B || o_out_char == 7'h2F
                     || o_out_char == PAD_CHAR;

    `B64E_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !o_valid)
    `B64E_ASSERT(a_legal_char, o_valid |-> legal_char)
    `B64E_ASSERT(a_out_hold, (o_valid && i_stall) |=> (o_valid && $stable(o_out_char) && $stable(o_last_char)))
    `B64E_ASSERT(a_in_hold, (i_valid && o_stall) |=> (i_valid && $stable(i_data_byte) && $stable(i_end_of_message)))

endmodule

bind base64_stream_encoder_unit b64e_checker u_b64e_checker (.*);
